/* rtl/core/itp_pkg.sv */
// Shared types, token codes and helper functions of the infix to postfix converter.
// Depends on nothing; every other file of the block imports it.

package itp_pkg;

  // Sizes
  localparam int STACK_DEPTH = 32;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 4;
  localparam int PRIO_W      = 3;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int TUSER_IN_W  = 1 + KIND_W;
  localparam int TUSER_OUT_W = KIND_W + 1;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NUM      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_X        = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LPAR     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RPAR     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_MUL      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DIV      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_UMINUS   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_FN_FIRST = 4'd9;
  localparam logic [KIND_W-1:0] KIND_FN_LAST  = 4'd14;
  localparam logic [KIND_W-1:0] KIND_END      = 4'd15;

  // Source of an emitted item
  typedef enum logic [1:0] {
    EMIT_TOP  = 2'd0,
    EMIT_ITEM = 2'd1,
    EMIT_END  = 2'd2
  } itp_emit_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      capture;
    logic      pop;
    logic      push;
    logic      emit;
    itp_emit_e emit_sel;
    logic      drain;
  } itp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_flush;
    logic is_operand;
    logic is_push_only;
    logic is_rpar;
    logic is_oper;
    logic count_zero;
    logic top_is_lpar;
    logic top_is_fn;
    logic prio_ge;
    logic can_emit;
    logic pend_valid;
    logic out_free;
  } itp_stat_t;

  function automatic logic is_fn(input logic [KIND_W-1:0] kind);
    return (kind >= KIND_FN_FIRST) && (kind <= KIND_FN_LAST);
  endfunction

  // Parentheses 0, + - 1, * / 2, unary minus 3, functions 4
  function automatic logic [PRIO_W-1:0] prio(input logic [KIND_W-1:0] kind);
    logic [PRIO_W-1:0] p;
    p = 3'd4;
    if (kind == KIND_LPAR || kind == KIND_RPAR) p = 3'd0;
    else if (kind == KIND_PLUS || kind == KIND_MINUS) p = 3'd1;
    else if (kind == KIND_MUL || kind == KIND_DIV) p = 3'd2;
    else if (kind == KIND_UMINUS) p = 3'd3;
    return p;
  endfunction

endpackage

/* rtl/core/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter (shunting yard with an operator stack).
// Depends on itp_pkg, itp_ctrl and itp_datapath.
//
// Usage: tokens enter on the s_axis channel, one item per token; tuser bit 0 set marks
// the end of an expression and flushes the stack. Results leave on the m_axis channel
// in postfix order; tlast marks the last result caused by one input item, and tuser
// bit 4 carries the sticky error flag (stack overflow or unmatched close parenthesis).
// The block takes one item at a time. An item is captured, passes through or is
// pushed, and each operator it pops from the stack is a step of its own; a close
// parenthesis that meets its open parenthesis takes a further step to drop it and to
// release a function waiting under it. Receiver stalls add to these steps. The stack
// has a single read and write port and pops one entry per cycle when the held-back
// result can move on. One result is held back until the next one is known, so that
// tlast can be set on it. An item that causes no result leaves no trace on m_axis.
// Reset clears the stack pointer, the error flag and both handshakes at once; the
// stack storage itself needs no clearing.
// When the receiver stalls, the output register holds its item and the controller
// waits at its next emit; no new input item is taken until all results of the current
// one have entered the output register.

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [VALUE_W-1:0]     s_axis_tdata_i,   // token_value
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser_i,   // op [0], token_kind [4:1]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [VALUE_W-1:0]     m_axis_tdata_o,   // out_value
  output logic [TUSER_OUT_W-1:0] m_axis_tuser_o,   // out_kind [3:0], error [4]
  output logic                   m_axis_tlast_o    // run_last
);

  itp_cmd_t  cmd;
  itp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  itp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* rtl/core/itp_ctrl.sv */
// Controller of the infix to postfix converter: walks one item through stack steps.
// Depends on itp_pkg for the command and status structs.

module itp_ctrl
  import itp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  itp_stat_t stat_i,
  output itp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_FNCHK = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  // Decide one stack step per cycle
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.emit_sel = EMIT_TOP;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        if (stat_i.is_flush) begin
          if (!stat_i.count_zero) begin
            if (stat_i.can_emit) begin
              cmd_o.pop  = 1'b1;
              cmd_o.emit = 1'b1;
            end
          end else if (stat_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_END;
            state_d        = S_DRAIN;
          end
        end else if (stat_i.is_operand) begin
          if (stat_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_ITEM;
            state_d        = S_DRAIN;
          end
        end else if (stat_i.is_push_only) begin
          cmd_o.push = 1'b1;
          state_d    = S_DRAIN;
        end else if (stat_i.is_rpar) begin
          if (stat_i.count_zero) begin
            state_d = S_DRAIN;
          end else if (stat_i.top_is_lpar) begin
            // drop the matching open parenthesis
            cmd_o.pop = 1'b1;
            state_d   = S_FNCHK;
          end else if (stat_i.can_emit) begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
          end
        end else if (stat_i.is_oper) begin
          if (!stat_i.count_zero && stat_i.prio_ge) begin
            if (stat_i.can_emit) begin
              cmd_o.pop  = 1'b1;
              cmd_o.emit = 1'b1;
            end
          end else begin
            cmd_o.push = 1'b1;
            state_d    = S_DRAIN;
          end
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_FNCHK: begin
        if (!stat_i.count_zero && stat_i.top_is_fn) begin
          if (stat_i.can_emit) begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
            state_d    = S_DRAIN;
          end
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // release the held-back item with its last mark
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.drain = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/itp_datapath.sv */
// Datapath of the infix to postfix converter: item register, operator stack,
// held-back result and output register. Depends on itp_pkg.

module itp_datapath
  import itp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itp_cmd_t               cmd_i,
  output itp_stat_t              stat_o,
  input  logic [VALUE_W-1:0]     in_data_i,
  input  logic [TUSER_IN_W-1:0]  in_user_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_W-1:0]     out_data_o,
  output logic [TUSER_OUT_W-1:0] out_user_o,
  output logic                   out_last_o
);

  // Item being worked on
  logic               op_q;
  logic [KIND_W-1:0]  kind_q;
  logic [VALUE_W-1:0] value_q;

  // Operator stack
  logic [KIND_W-1:0] stack_q [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  lpar_q, lpar_d;
  logic [CNT_W-1:0]  count_m1;
  logic [KIND_W-1:0] top;
  logic              full;
  logic              err_q, err_d;

  // Held-back result and output register
  logic               pend_valid_q, pend_valid_d;
  logic [KIND_W-1:0]  pend_kind_q;
  logic [VALUE_W-1:0] pend_value_q;
  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  out_kind_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_last_q;
  logic               out_err_q;
  logic               out_load;
  logic               out_free;
  logic [KIND_W-1:0]  new_kind;
  logic [VALUE_W-1:0] new_value;
  logic [KIND_W-1:0]  in_kind;

  assign in_kind  = in_user_i[KIND_W:1];
  assign count_m1 = count_q - CNT_W'(1);
  assign top      = stack_q[count_m1[IDX_W-1:0]];
  assign full     = (count_q >= CNT_W'(STACK_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.emit && pend_valid_q) || cmd_i.drain;

  // Status toward the controller
  always_comb begin
    stat_o              = '0;
    stat_o.is_flush     = op_q;
    stat_o.is_operand   = (kind_q == KIND_NUM) || (kind_q == KIND_X);
    stat_o.is_push_only = (kind_q == KIND_LPAR) || is_fn(kind_q);
    stat_o.is_rpar      = (kind_q == KIND_RPAR);
    stat_o.is_oper      = (kind_q >= KIND_PLUS) && (kind_q <= KIND_UMINUS);
    stat_o.count_zero   = (count_q == '0);
    stat_o.top_is_lpar  = (top == KIND_LPAR);
    stat_o.top_is_fn    = is_fn(top);
    stat_o.prio_ge      = (prio(top) >= prio(kind_q));
    stat_o.can_emit     = !pend_valid_q || out_free;
    stat_o.pend_valid   = pend_valid_q;
    stat_o.out_free     = out_free;
  end

  // Select the result being emitted
  always_comb begin
    case (cmd_i.emit_sel)
      EMIT_TOP: begin
        new_kind  = top;
        new_value = '0;
      end
      EMIT_ITEM: begin
        new_kind  = kind_q;
        new_value = (kind_q == KIND_NUM) ? value_q : '0;
      end
      EMIT_END: begin
        new_kind  = KIND_END;
        new_value = '0;
      end
      default: begin
        new_kind  = KIND_END;
        new_value = '0;
      end
    endcase
  end

  // Stack pointer, open-parenthesis count and sticky error
  always_comb begin
    count_d = count_q;
    lpar_d  = lpar_q;
    err_d   = err_q;
    if (cmd_i.capture && !in_user_i[0] && (in_kind == KIND_RPAR) && (lpar_q == '0)) begin
      err_d = 1'b1;
    end
    if (cmd_i.pop) begin
      count_d = count_m1;
      if (top == KIND_LPAR) lpar_d = lpar_q - CNT_W'(1);
    end else if (cmd_i.push) begin
      if (full) begin
        err_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (kind_q == KIND_LPAR) lpar_d = lpar_q + CNT_W'(1);
      end
    end
  end

  // Held-back result and output handshake
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.emit) pend_valid_d = 1'b1;
    else if (cmd_i.drain) pend_valid_d = 1'b0;
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      lpar_q       <= '0;
      err_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      lpar_q       <= lpar_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_user_i[0];
      kind_q  <= in_kind;
      value_q <= in_data_i;
    end
    if (cmd_i.push && !full) begin
      stack_q[count_q[IDX_W-1:0]] <= kind_q;
    end
    if (cmd_i.emit) begin
      pend_kind_q  <= new_kind;
      pend_value_q <= new_value;
    end
    if (out_load) begin
      out_kind_q  <= pend_kind_q;
      out_value_q <= pend_value_q;
      out_last_q  <= cmd_i.drain;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_value_q;
  assign out_user_o  = {out_err_q, out_kind_q};
  assign out_last_o  = out_last_q;

endmodule

/* rtl/core/itp_checker.sv */
// Port-level checks of the infix to postfix converter, bound to the top level.
// Depends on itp_pkg.

module itp_checker
  import itp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [VALUE_W-1:0]     m_axis_tdata_o,
  input logic [TUSER_OUT_W-1:0] m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // Remember an error once it has been shown
  logic err_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tuser_o[KIND_W]) begin
      err_seen_q <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // The end marker closes the run of its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[KIND_W-1:0] == KIND_END) |-> m_axis_tlast_o)
    else $error("end marker without tlast");

  // The error flag never clears after it has been shown
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err_seen_q |-> m_axis_tuser_o[KIND_W])
    else $error("error flag cleared");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

/* test/postfix_checker.sv */
// Checker of the infix to postfix converter: watches both stream channels, predicts the
// postfix items of every accepted token and compares them in order. Depends on itp_pkg.

module postfix_checker
  import itp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [VALUE_W-1:0]     s_axis_tdata_i,   // token_value
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser_i,   // op [0], token_kind [4:1]
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [VALUE_W-1:0]     m_axis_tdata_i,   // out_value
  input  logic [TUSER_OUT_W-1:0] m_axis_tuser_i,   // out_kind [3:0], error [4]
  input  logic                   m_axis_tlast_i,   // run_last
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               err;
  } postfix_tok_t;

  // Predicted operator stack and sticky error
  logic [KIND_W-1:0] op_stack_q [STACK_DEPTH];
  int                stack_top  = 0;
  logic              err_sticky = 1'b0;

  // Items of the current token, then all items still owed by the block
  postfix_tok_t      run_q[$];
  postfix_tok_t      postfix_q[$];
  int                fail_count    = 0;
  int                expected_left = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_left;

  function automatic int rank(input logic [KIND_W-1:0] k);
    case (k)
      KIND_LPAR, KIND_RPAR:  return 0;
      KIND_PLUS, KIND_MINUS: return 1;
      KIND_MUL, KIND_DIV:    return 2;
      KIND_UMINUS:           return 3;
      default:               return 4;
    endcase
  endfunction

  function automatic logic is_func(input logic [KIND_W-1:0] k);
    return (k >= KIND_FN_FIRST) && (k <= KIND_FN_LAST);
  endfunction

  task automatic log_miss(input string what, input logic [VALUE_W-1:0] got,
                          input logic [VALUE_W-1:0] want);
    $display("%0t postfix mismatch: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic stage(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
    postfix_tok_t t;
    t.kind  = kind;
    t.value = value;
    t.last  = 1'b0;
    t.err   = 1'b0;
    run_q.push_back(t);
  endtask

  task automatic pop_and_stage();
    stack_top--;
    stage(op_stack_q[stack_top], '0);
  endtask

  // Drop the push and flag it when the stack is full
  task automatic push_op(input logic [KIND_W-1:0] kind);
    if (stack_top >= STACK_DEPTH) begin
      err_sticky = 1'b1;
    end else begin
      op_stack_q[stack_top] = kind;
      stack_top++;
    end
  endtask

  // Shunting-yard step for one accepted token
  task automatic shunt_token(input logic flush, input logic [KIND_W-1:0] kind,
                             input logic [VALUE_W-1:0] value);
    int           p;
    postfix_tok_t t;
    run_q.delete();
    if (flush) begin
      while (stack_top > 0) pop_and_stage();
      stage(KIND_END, '0);
    end else if (kind == KIND_NUM) begin
      stage(KIND_NUM, value);
    end else if (kind == KIND_X) begin
      stage(KIND_X, '0);
    end else if (kind == KIND_LPAR || is_func(kind)) begin
      push_op(kind);
    end else if (kind == KIND_RPAR) begin
      while (stack_top > 0 && op_stack_q[stack_top-1] != KIND_LPAR) pop_and_stage();
      if (stack_top == 0) begin
        err_sticky = 1'b1;
      end else begin
        // drop the open parenthesis, then release a function waiting under it
        stack_top--;
        if (stack_top > 0 && is_func(op_stack_q[stack_top-1])) pop_and_stage();
      end
    end else if (kind >= KIND_PLUS && kind <= KIND_UMINUS) begin
      p = rank(kind);
      while (stack_top > 0 && rank(op_stack_q[stack_top-1]) >= p) pop_and_stage();
      push_op(kind);
    end
    // error reflects the state after the whole token; tlast marks its final item
    foreach (run_q[i]) begin
      t      = run_q[i];
      t.err  = err_sticky;
      t.last = (i == run_q.size() - 1);
      postfix_q.push_back(t);
    end
  endtask

  // Compare each accepted item, then predict for each accepted token
  always @(posedge clk_i) begin
    postfix_tok_t want;
    if (!rst_ni) begin
      stack_top  = 0;
      err_sticky = 1'b0;
      postfix_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (postfix_q.size() == 0) begin
          log_miss("item with nothing expected, kind",
                   VALUE_W'(m_axis_tuser_i[KIND_W-1:0]), '0);
        end else begin
          want = postfix_q.pop_front();
          if (m_axis_tuser_i[KIND_W-1:0] != want.kind)
            log_miss("kind", VALUE_W'(m_axis_tuser_i[KIND_W-1:0]), VALUE_W'(want.kind));
          if (m_axis_tdata_i != want.value)
            log_miss("value", m_axis_tdata_i, want.value);
          if (m_axis_tuser_i[KIND_W] != want.err)
            log_miss("error flag", VALUE_W'(m_axis_tuser_i[KIND_W]), VALUE_W'(want.err));
          if (m_axis_tlast_i != want.last)
            log_miss("tlast", VALUE_W'(m_axis_tlast_i), VALUE_W'(want.last));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        shunt_token(s_axis_tuser_i[0], s_axis_tuser_i[KIND_W:1], s_axis_tdata_i);
    end
    expected_left = postfix_q.size();
  end

endmodule

/* test/infix_to_postfix_converter_test.sv */
// Top of the infix to postfix converter test: clock, reset, token stimulus, receiver
// stalls, watchdog and verdict. Depends on itp_pkg, the converter and postfix_checker.

module infix_to_postfix_converter_test;
  import itp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 50;

  localparam logic [KIND_W-1:0] FN_COS  = KIND_FN_FIRST + 4'd1;
  localparam logic [KIND_W-1:0] FN_TAN  = KIND_FN_FIRST + 4'd2;
  localparam logic [KIND_W-1:0] FN_CTG  = KIND_FN_FIRST + 4'd3;
  localparam logic [KIND_W-1:0] FN_SQRT = KIND_FN_FIRST + 4'd4;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [VALUE_W-1:0]     s_data  = '0;
  logic [TUSER_IN_W-1:0]  s_user  = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [VALUE_W-1:0]     m_data;
  logic [TUSER_OUT_W-1:0] m_user;
  logic                   m_last;

  int fail_cnt;
  int pending_cnt;
  int tokens_sent = 0;
  int quiet_cycles = 0;
  int ready_left = 0;
  int stall_left = 0;

  infix_to_postfix_converter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  postfix_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .m_axis_tlast_i (m_last),
    .fail_count_o   (fail_cnt),
    .pending_o      (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: stretches of ready, broken by stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_ready = 1'b0;
      stall_left--;
    end else begin
      m_ready = 1'b1;
      if (ready_left > 0) begin
        ready_left--;
      end else begin
        ready_left = $urandom_range(0, 30);
        stall_left = gap_len();
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("infix_to_postfix_converter_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one token after a random gap and hold it until accepted
  task automatic send_token(input logic op, input logic [KIND_W-1:0] kind,
                            input logic [VALUE_W-1:0] value);
    int gap;
    gap = gap_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = {kind, op};
    s_data  = value;
    do @(posedge clk_i); while (!s_ready);
    if (op || kind != KIND_END) tokens_sent++;
  endtask

  // Any token at all; a close parenthesis or a flush only when rough
  task automatic send_noise(input bit rough);
    logic [KIND_W-1:0] kind;
    logic              op;
    kind = KIND_W'($urandom_range(0, 15));
    op   = rough && ($urandom_range(0, 7) == 0);
    if (!rough && kind == KIND_RPAR) kind = KIND_END;
    send_token(op, kind, $urandom);
  endtask

  // Expression with random content, now and then broken by a noise token, closed by a flush
  task automatic send_expression(input int max_ops, input bit rough);
    int open_cnt;
    int ops;
    int r;
    bit want_operand;
    open_cnt     = 0;
    ops          = 0;
    want_operand = 1'b1;
    while (want_operand || open_cnt > 0 || ops < max_ops) begin
      if ($urandom_range(0, 11) == 0) send_noise(rough);
      if (want_operand) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          send_token(1'b0, KIND_NUM, $urandom);
          want_operand = 1'b0;
        end else if (r < 5) begin
          send_token(1'b0, KIND_X, $urandom);
          want_operand = 1'b0;
        end else if (r < 7 && open_cnt < 4 && ops < max_ops) begin
          send_token(1'b0, KIND_LPAR, $urandom);
          open_cnt++;
          ops++;
        end else if (r < 9 && open_cnt < 4 && ops < max_ops) begin
          send_token(1'b0, KIND_W'(KIND_FN_FIRST + $urandom_range(0, 5)), $urandom);
          send_token(1'b0, KIND_LPAR, $urandom);
          open_cnt++;
          ops++;
        end else if (r == 9 && ops < max_ops) begin
          send_token(1'b0, KIND_UMINUS, $urandom);
          ops++;
        end else begin
          send_token(1'b0, KIND_NUM, $urandom);
          want_operand = 1'b0;
        end
      end else if (open_cnt > 0 && (ops >= max_ops || $urandom_range(0, 2) == 0)) begin
        send_token(1'b0, KIND_RPAR, $urandom);
        open_cnt--;
      end else begin
        send_token(1'b0, KIND_W'(KIND_PLUS + $urandom_range(0, 3)), $urandom);
        ops++;
        want_operand = 1'b1;
      end
    end
    send_token(1'b1, KIND_W'($urandom_range(0, 15)), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // All four binary operators with extreme literals
    send_token(1'b0, KIND_NUM, 32'h0000_0000);
    send_token(1'b0, KIND_PLUS, $urandom);
    send_token(1'b0, KIND_X, 32'hFFFF_FFFF);
    send_token(1'b0, KIND_MUL, $urandom);
    send_token(1'b0, KIND_NUM, 32'hFFFF_FFFF);
    send_token(1'b0, KIND_MINUS, $urandom);
    send_token(1'b0, KIND_NUM, 32'h5A5A_A5A5);
    send_token(1'b0, KIND_DIV, $urandom);
    send_token(1'b0, KIND_X, $urandom);
    send_token(1'b1, KIND_RPAR, 32'hFFFF_FFFF);

    // Unary minus chain over nested function calls
    send_token(1'b0, KIND_UMINUS, $urandom);
    send_token(1'b0, KIND_UMINUS, $urandom);
    send_token(1'b0, KIND_FN_FIRST, $urandom);
    send_token(1'b0, KIND_LPAR, $urandom);
    send_token(1'b0, FN_COS, $urandom);
    send_token(1'b0, KIND_LPAR, $urandom);
    send_token(1'b0, FN_TAN, $urandom);
    send_token(1'b0, KIND_LPAR, $urandom);
    send_token(1'b0, KIND_X, $urandom);
    send_token(1'b0, KIND_RPAR, $urandom);
    send_token(1'b0, KIND_RPAR, $urandom);
    send_token(1'b0, KIND_RPAR, $urandom);
    send_token(1'b1, KIND_NUM, 32'h0000_0000);

    // Stray open parenthesis flushed, end kind sent as a plain token
    send_token(1'b0, FN_CTG, $urandom);
    send_token(1'b0, KIND_LPAR, $urandom);
    send_token(1'b0, FN_SQRT, $urandom);
    send_token(1'b0, KIND_FN_LAST, $urandom);
    send_token(1'b0, KIND_END, $urandom);
    send_token(1'b1, KIND_END, $urandom);

    // Clean expressions while the error flag is still low
    while (tokens_sent < 100) send_expression($urandom_range(1, 6), 1'b0);

    // Unmatched close parenthesis
    send_token(1'b0, KIND_NUM, $urandom);
    send_token(1'b0, KIND_PLUS, $urandom);
    send_token(1'b0, KIND_X, $urandom);
    send_token(1'b0, KIND_RPAR, $urandom);
    send_token(1'b1, KIND_NUM, $urandom);

    // Fill the stack past its depth, push an operator onto it, flush it all
    repeat (STACK_DEPTH + 1) begin
      if ($urandom_range(0, 1) == 0) send_token(1'b0, KIND_LPAR, $urandom);
      else send_token(1'b0, KIND_W'(KIND_FN_FIRST + $urandom_range(0, 5)), $urandom);
    end
    send_token(1'b0, KIND_PLUS, $urandom);
    send_token(1'b1, KIND_NUM, $urandom);

    // Expressions mixed with arbitrary tokens
    while (tokens_sent < 180) begin
      if ($urandom_range(0, 3) == 0) send_noise(1'b1);
      else send_expression($urandom_range(1, 6), 1'b1);
    end

    @(negedge clk_i);
    s_valid = 1'b0;
    wait (pending_cnt == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("infix_to_postfix_converter_test: done, clean");
    end else begin
      $display("infix_to_postfix_converter_test: done, errors");
    end
    $finish;
  end

endmodule
